[hdl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
// No dependencies; every other file imports this package.
`default_nettype none

package ple_pkg;

   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 7;

   localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]         list_length;
   } res_type;

endpackage

`default_nettype wire

[hdl/ple_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on ple_pkg for field widths.
`default_nettype none

interface ple_req_if;
   import ple_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ple_rsp_if;
   import ple_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [DATA_W-1:0] read_value;
   logic [LEN_W-1:0]         list_length;

   modport source (output valid, output ok, output read_value, output list_length,
                   input ready);
   modport sink   (input valid, input ok, input read_value, input list_length,
                   output ready);
endinterface

`default_nettype wire

[hdl/ple_ram.sv]
// Element store: one write port and one read port with registered read data.
// Depends on ple_pkg for the data width.
`default_nettype none

module ple_ram #(
   parameter int  DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [AW-1:0]             waddr,
   input  wire logic [ple_pkg::DATA_W-1:0] wdata,
   input  wire logic                      re,
   input  wire logic [AW-1:0]             raddr,
   output logic      [ple_pkg::DATA_W-1:0] rdata
);
   import ple_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[hdl/ple_ctrl.sv]
// Sequencer for the list: decodes a request, then walks a write address
// through the store with one shared step/compare unit. Depends on ple_pkg.
`default_nettype none

module ple_ctrl #(
   parameter int  CAPACITY = 64,
   localparam int AW       = $clog2(CAPACITY)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      cmd_valid,
   output logic                           cmd_ready,
   input  wire ple_pkg::cmd_type          cmd,
   output logic                           res_valid,
   input  wire logic                      res_ready,
   output ple_pkg::res_type               res,
   output logic                           ram_we,
   output logic      [AW-1:0]             ram_waddr,
   output logic      [ple_pkg::DATA_W-1:0] ram_wdata,
   output logic                           ram_re,
   output logic      [AW-1:0]             ram_raddr,
   input  wire logic [ple_pkg::DATA_W-1:0] ram_rdata
);
   import ple_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam int LW = (CW > LEN_W) ? CW : LEN_W;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_ZERO     = 6'b000010,
      S_SHIFT_RD = 6'b000100,
      S_SHIFT_WR = 6'b001000,
      S_RD_WAIT  = 6'b010000,
      S_DONE     = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            wa_ff, wa_in;
   logic [AW-1:0]            lim_ff, lim_in;
   logic                     down_ff, down_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic                     ok_ff, ok_in;
   logic signed [DATA_W-1:0] rd_ff, rd_in;

   logic [XW-1:0] pos_x, cnt_x, cap_x, pos_m1, cnt_m1;
   logic          pos_in_rng;
   logic [AW-1:0] step;
   logic          at_lim;
   logic [LW-1:0] cnt_wide;

   assign pos_x      = XW'(cmd.position);
   assign cnt_x      = XW'(count_ff);
   assign cap_x      = XW'(CAPACITY);
   assign pos_m1     = pos_x - XW'(1);
   assign cnt_m1     = cnt_x - XW'(1);
   assign pos_in_rng = (pos_x != '0) && (pos_x <= cnt_x);

   // Shared unit: one address step and one limit compare serve every walk
   assign step   = down_ff ? (wa_ff - AW'(1)) : (wa_ff + AW'(1));
   assign at_lim = (wa_ff == lim_ff);

   assign cmd_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   assign cnt_wide        = LW'(count_ff);
   assign res.ok          = ok_ff;
   assign res.read_value  = rd_ff;
   assign res.list_length = cnt_wide[LEN_W-1:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      wa_in     = wa_ff;
      lim_in    = lim_ff;
      down_in   = down_ff;
      val_in    = val_ff;
      ok_in     = ok_ff;
      rd_in     = rd_ff;
      ram_we    = 1'b0;
      ram_waddr = wa_ff;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = step;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               ok_in    = 1'b0;
               rd_in    = '0;
               val_in   = cmd.value;
               state_in = S_DONE;
               case (cmd.op)
                  OP_CREATE: begin
                     if (pos_x <= cap_x) begin
                        ok_in    = 1'b1;
                        count_in = CW'(pos_x);
                        wa_in    = '0;
                        lim_in   = AW'(pos_m1);
                        down_in  = 1'b0;
                        if (pos_x != '0) begin
                           state_in = S_ZERO;
                        end
                     end
                  end
                  OP_UPDATE: begin
                     if (pos_in_rng) begin
                        ok_in     = 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = AW'(pos_m1);
                        ram_wdata = cmd.value;
                     end
                  end
                  OP_INSERT: begin
                     if ((pos_x != '0) && (pos_x <= cnt_x + XW'(1)) && (cnt_x < cap_x)) begin
                        ok_in    = 1'b1;
                        count_in = count_ff + CW'(1);
                        wa_in    = AW'(cnt_x);
                        lim_in   = AW'(pos_m1);
                        down_in  = 1'b1;
                        state_in = S_SHIFT_RD;
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_in_rng) begin
                        ok_in    = 1'b1;
                        count_in = count_ff - CW'(1);
                        wa_in    = AW'(pos_m1);
                        lim_in   = AW'(cnt_m1);
                        down_in  = 1'b0;
                        state_in = S_SHIFT_RD;
                     end
                  end
                  OP_READ: begin
                     if (pos_in_rng) begin
                        ok_in     = 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = AW'(pos_m1);
                        state_in  = S_RD_WAIT;
                     end
                  end
                  OP_CLEAR: begin
                     if (cnt_x != '0) begin
                        ok_in    = 1'b1;
                        wa_in    = '0;
                        lim_in   = AW'(cnt_m1);
                        down_in  = 1'b0;
                        state_in = S_ZERO;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ZERO: begin
            ram_we = 1'b1;
            if (at_lim) begin
               state_in = S_DONE;
            end else begin
               wa_in = step;
            end
         end
         S_SHIFT_RD: begin
            if (at_lim) begin
               // drop the new value into the gap left by the shift
               if (down_ff) begin
                  ram_we    = 1'b1;
                  ram_wdata = val_ff;
               end
               state_in = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            wa_in     = step;
            state_in  = S_SHIFT_RD;
         end
         S_RD_WAIT: begin
            rd_in    = signed'(ram_rdata);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff   <= wa_in;
      lim_ff  <= lim_in;
      down_ff <= down_in;
      val_ff  <= val_in;
      ok_ff   <= ok_in;
      rd_ff   <= rd_in;
   end

endmodule

`default_nettype wire

[hdl/positional_list_engine.sv]
// Top level of the positional list engine: sequencer, element store and
// response register. Depends on ple_pkg, ple_if, ple_ctrl and ple_ram.
//
// Usage: req_chan carries one request item (op, position, value); rsp_chan
// returns exactly one result item (ok, read_value, list_length) for each,
// in order. Both channels move an item when valid and ready are high at a
// rising clock edge.
// One request is worked on at a time; req_chan.ready is high only while the
// sequencer is idle. An update or a failed request goes straight to its
// result; a read waits for the registered read data; create and clear
// zero each entry of the new or old list (a create of size zero writes
// none); insert and remove shift the items behind the position. Each moved
// element takes a read then a write on the single read and write ports of
// the element store; zeroing writes one per cycle.
// The result sits in an output register, so a new request is taken while a
// finished result still waits; a stalled receiver holds the sequencer in
// its final step only once that register is also full.
// Reset (synchronous) empties the list and drops any pending result; no
// sweep of the store is needed, since only entries below the length are
// ever read.
`default_nettype none

module positional_list_engine #(
   parameter int CAPACITY = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   ple_req_if.sink   req_chan,
   ple_rsp_if.source rsp_chan
);
   import ple_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   cmd_type           cmd;
   res_type           res;
   logic              res_valid;
   logic              res_ready;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   logic    rsp_valid_ff;
   res_type rsp_res_ff;

   assign cmd.op       = req_chan.op;
   assign cmd.position = req_chan.position;
   assign cmd.value    = req_chan.value;

   ple_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_chan.valid),
      .cmd_ready (req_chan.ready),
      .cmd       (cmd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   ple_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Output register frees the sequencer once its result is captured
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ok          = rsp_res_ff.ok;
   assign rsp_chan.read_value  = rsp_res_ff.read_value;
   assign rsp_chan.list_length = rsp_res_ff.list_length;

endmodule

`default_nettype wire

[hdl/ple_chk.sv]
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg for field widths.
`default_nettype none

module ple_chk (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic                      rsp_ok,
   input wire logic [ple_pkg::DATA_W-1:0] rsp_read_value,
   input wire logic [ple_pkg::LEN_W-1:0]  rsp_list_length
);
   import ple_pkg::*;

   // Results register is emptied by reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled result holds its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_ok) && $stable(rsp_read_value)
         && $stable(rsp_list_length))
      else $error("stalled response changed");

   // One request at a time: the sequencer is busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous still in progress");

   // A failed request never returns data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_read_value == '0)
      else $error("failed request returned data");

endmodule

bind positional_list_engine ple_chk u_ple_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_ok          (rsp_chan.ok),
   .rsp_read_value  (rsp_chan.read_value),
   .rsp_list_length (rsp_chan.list_length)
);

`default_nettype wire
